[hdl/lfs_pkg.sv]
`default_nettype none

package lfs_pkg;

  localparam int FP_W       = 32;
  localparam int CODE_W     = 8;
  localparam int NUM_CODES  = 256;
  localparam int PIPE_DEPTH = CODE_W;
  localparam int NUM_LANES  = 4;
  localparam int LIN_CODES  = 10;
  localparam int EXP_OFFSET = 150;
  localparam int LIN_SLOPE  = 32946;
  localparam int POW_BASE   = 53805;
  localparam int POW_STEP   = 200;
  localparam int POW_BIAS   = 2705;
  localparam int POW_ROOT   = 12;
  localparam int POW_EXP    = 5;

  localparam logic [FP_W-1:0] SEARCH_LO = 32'h3880_0000;
  localparam logic [FP_W-1:0] SEARCH_HI = 32'h3F80_0000;

  typedef logic [511:0] wide_t;
  typedef logic [FP_W-1:0] thr_table_t [NUM_CODES];

  function automatic logic code_reached(input logic [FP_W-1:0] p, input int k);
    wide_t m;
    wide_t lhs;
    wide_t rhs;
    wide_t r;
    int    sh;
    int    i;
    m  = wide_t'({1'b1, p[22:0]});
    sh = EXP_OFFSET - int'(p[30:23]);
    if (k <= LIN_CODES) begin
      lhs = m * wide_t'(LIN_SLOPE);
      rhs = wide_t'(5 * (2 * k - 1)) << sh;
    end else begin
      lhs = wide_t'(1);
      for (i = 0; i < POW_EXP; i++) begin
        lhs = lhs * m;
      end
      for (i = 0; i < POW_ROOT; i++) begin
        lhs = lhs * wide_t'(POW_BASE);
      end
      r   = wide_t'(POW_STEP * k + POW_BIAS);
      rhs = wide_t'(1);
      for (i = 0; i < POW_ROOT; i++) begin
        rhs = rhs * r;
      end
      rhs = rhs << (POW_EXP * sh);
    end
    return lhs >= rhs;
  endfunction

  // smallest positive float pattern that reaches each code from 1 up; code 0 gets zero
  function automatic thr_table_t build_thresholds();
    thr_table_t      t;
    logic [FP_W-1:0] lo;
    logic [FP_W-1:0] hi;
    logic [FP_W-1:0] mid;
    int              k;
    t[0] = '0;
    for (k = 1; k < NUM_CODES; k++) begin
      lo = SEARCH_LO;
      hi = SEARCH_HI;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (code_reached(mid, k)) begin
          hi = mid;
        end else begin
          lo = mid + 1'b1;
        end
      end
      t[k] = lo;
    end
    return t;
  endfunction

  localparam thr_table_t THRESH = build_thresholds();

endpackage

`default_nettype wire

[hdl/lfs_in_if.sv]
`default_nettype none

interface lfs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_linear;
  logic [31:0] green_linear;
  logic [31:0] blue_linear;
  logic [31:0] alpha_linear;

  modport source (
    output valid, red_linear, green_linear, blue_linear, alpha_linear,
    input  ready
  );
  modport sink (
    input  valid, red_linear, green_linear, blue_linear, alpha_linear,
    output ready
  );
endinterface

`default_nettype wire

[hdl/lfs_out_if.sv]
`default_nettype none

interface lfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_srgb;
  logic [7:0] green_srgb;
  logic [7:0] blue_srgb;
  logic [7:0] alpha_srgb;

  modport source (
    output valid, red_srgb, green_srgb, blue_srgb, alpha_srgb,
    input  ready
  );
  modport sink (
    input  valid, red_srgb, green_srgb, blue_srgb, alpha_srgb,
    output ready
  );
endinterface

`default_nettype wire

[hdl/lfs_lane.sv]
`default_nettype none

module lfs_lane
  import lfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [FP_W-1:0]   pattern,
  output logic      [CODE_W-1:0] code
);

  logic [FP_W-1:0]   pat     [PIPE_DEPTH-1];
  logic [CODE_W-1:0] cd      [PIPE_DEPTH];
  logic [FP_W-1:0]   src_pat [PIPE_DEPTH];
  logic [CODE_W-1:0] src_cd  [PIPE_DEPTH];
  logic [CODE_W-1:0] cand    [PIPE_DEPTH];
  logic [CODE_W-1:0] pick    [PIPE_DEPTH];
  logic [FP_W-1:0]   pat_in;
  logic              kill;

  // negative values and NaN encode as zero
  assign kill   = pattern[FP_W-1] || (pattern[30:23] == 8'hFF && pattern[22:0] != '0);
  assign pat_in = kill ? '0 : pattern;

  always_comb begin
    src_pat[0] = pat_in;
    src_cd[0]  = '0;
    for (int j = 1; j < PIPE_DEPTH; j++) begin
      src_pat[j] = pat[j-1];
      src_cd[j]  = cd[j-1];
    end
    for (int j = 0; j < PIPE_DEPTH; j++) begin
      cand[j] = src_cd[j] | (CODE_W'(1) << (PIPE_DEPTH - 1 - j));
      pick[j] = (src_pat[j] >= THRESH[cand[j]]) ? cand[j] : src_cd[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < PIPE_DEPTH; j++) begin
        cd[j] <= pick[j];
      end
      for (int j = 0; j < PIPE_DEPTH - 1; j++) begin
        pat[j] <= src_pat[j];
      end
    end
  end

  assign code = cd[PIPE_DEPTH-1];

endmodule

`default_nettype wire

[hdl/linear_float_to_srgb8_pixel.sv]
// Throughput: one pixel per cycle while no result request waits; each channel runs
// an 8-stage binary search over a 256-entry threshold table, one code bit per stage.
// The pipeline stalls as a whole only while the result request is not taken.
// Reset clears the stage valid bits; the data path registers are not reset.
`default_nettype none

module linear_float_to_srgb8_pixel
  import lfs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  lfs_in_if.sink   pix_in,
  lfs_out_if.source pix_out
);

  logic [PIPE_DEPTH-1:0] vld;
  logic                  adv;
  logic [FP_W-1:0]       lane_in  [NUM_LANES];
  logic [CODE_W-1:0]     lane_out [NUM_LANES];

  assign adv          = !vld[PIPE_DEPTH-1] || pix_out.ready;
  assign pix_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], pix_in.valid};
    end
  end

  assign lane_in[0] = pix_in.red_linear;
  assign lane_in[1] = pix_in.green_linear;
  assign lane_in[2] = pix_in.blue_linear;
  assign lane_in[3] = pix_in.alpha_linear;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lfs_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .pattern (lane_in[g]),
      .code    (lane_out[g])
    );
  end

  assign pix_out.valid      = vld[PIPE_DEPTH-1];
  assign pix_out.red_srgb   = lane_out[0];
  assign pix_out.green_srgb = lane_out[1];
  assign pix_out.blue_srgb  = lane_out[2];
  assign pix_out.alpha_srgb = lane_out[3];

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.ready |=> pix_out.valid)
    else $error("result request dropped while stalled");

  a_enter_pipe: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> pix_out.valid && !pix_out.ready)
    else $error("input stalled without a blocked result");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.ready && !vld[PIPE_DEPTH-2] |=> !pix_out.valid)
    else $error("result request repeated");
`endif

endmodule

`default_nettype wire
